@@ src/vfcm_pkg.sv @@
// Shared types and constants for the voxel face culling mesher.
// Holds the request and face record structs and the control/datapath interface.
// No dependencies.
package vfcm_pkg;

  localparam int COORD_W  = 4;
  localparam int DIR_W    = 3;
  localparam int NUM_DIRS = 6;

  // Request operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_MESH  = 1'b1;

  // Face direction codes, also bit positions in the exposure mask
  localparam logic [DIR_W-1:0] DIR_XP = 3'd0;
  localparam logic [DIR_W-1:0] DIR_XM = 3'd1;
  localparam logic [DIR_W-1:0] DIR_YP = 3'd2;
  localparam logic [DIR_W-1:0] DIR_YM = 3'd3;
  localparam logic [DIR_W-1:0] DIR_ZP = 3'd4;
  localparam logic [DIR_W-1:0] DIR_ZM = 3'd5;
  localparam logic [DIR_W-1:0] DIR_MAX = DIR_ZM;

  typedef struct packed {
    logic               operation;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] pos_z;
    logic               full_req;
  } in_req_t;

  typedef struct packed {
    logic [COORD_W-1:0] face_x;
    logic [COORD_W-1:0] face_y;
    logic [COORD_W-1:0] face_z;
    logic [DIR_W-1:0]   face_dir;
    logic               last;
  } face_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_RD,
    ST_WR_WR,
    ST_M_C,
    ST_M_YP,
    ST_M_YM,
    ST_M_ZP,
    ST_M_ZM,
    ST_M_END,
    ST_EMIT
  } state_e;

  // Which row of the grid memory to read
  typedef enum logic [2:0] {
    ROW_CENTER,
    ROW_YP,
    ROW_YM,
    ROW_ZP,
    ROW_ZM
  } row_sel_e;

  // Which neighbor check the returned row data feeds
  typedef enum logic [2:0] {
    CAP_NONE,
    CAP_X,
    CAP_YP,
    CAP_YM,
    CAP_ZP,
    CAP_ZM
  } cap_e;

  typedef struct packed {
    logic     load;
    logic     clr_en;
    logic     rd_en;
    row_sel_e rd_sel;
    cap_e     cap_sel;
    logic     wr_row;
    logic     emit_en;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_mesh;
    logic in_grid;
    logic emit_done;
  } dp_sts_t;

endpackage

@@ src/voxel_face_culling_mesher_unit.sv @@
// Top level of the voxel face mesher: controller plus datapath.
// Depends on vfcm_pkg, vfcm_ctrl and vfcm_datapath.
//
//  channel  | signals                          | payload
//  ---------+----------------------------------+----------------
//  request  | in_valid_i / in_ready_o          | in_req_i  (in_req_t)
//  face     | out_valid_o / out_ready_i        | out_face_o (face_t)
//
// After reset the grid memory is cleared one row per cycle, all GRID_SIZE^2 rows
// (256 at the default size), during which no request is taken.
// A write request passes through accept, row read and row write-back.
// A mesh request makes five row reads through the single memory read port, then
// moves one face per cycle into the output register unless the output stalls.
// A stalled face output holds emission; the last face may wait while the next
// request is accepted.
module voxel_face_culling_mesher_unit import vfcm_pkg::*; #(
  parameter int GRID_SIZE = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  in_req_t in_req_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output face_t   out_face_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  vfcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vfcm_datapath #(
    .GRID_SIZE (GRID_SIZE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_face_o  (out_face_o)
  );

endmodule

@@ src/vfcm_datapath.sv @@
// Datapath of the voxel face mesher: row-organized occupancy memory,
// clear counter, neighbor exposure mask and face output register.
// Depends on vfcm_pkg.
module vfcm_datapath import vfcm_pkg::*; #(
  parameter int GRID_SIZE = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  in_req_t in_req_i,
  input  dp_cmd_t cmd_i,
  output dp_sts_t sts_o,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output face_t   out_face_o
);

  localparam int ROWS = GRID_SIZE * GRID_SIZE;
  localparam int AW   = $clog2(ROWS);
  localparam int XW   = $clog2(GRID_SIZE);
  localparam int EW   = 8;
  localparam logic [EW-1:0] GS       = EW'(GRID_SIZE);
  localparam logic [AW-1:0] LAST_ROW = AW'(ROWS - 1);

  // Row address of (y, z); only used for in-grid coordinates
  function automatic logic [AW-1:0] row_addr(logic [EW-1:0] yy, logic [EW-1:0] zz);
    logic [15:0] a;
    a = 16'(yy) + 16'(zz) * 16'(GRID_SIZE);
    return a[AW-1:0];
  endfunction

  // Grid memory: one row holds all x for a given (y, z)
  logic [GRID_SIZE-1:0] mem [ROWS];
  logic [GRID_SIZE-1:0] rdata_q;

  in_req_t             req_q;
  logic [AW-1:0]       clr_cnt_q, clr_cnt_d;
  logic [NUM_DIRS-1:0] mask_q, mask_d;
  logic                center_q, center_d;
  logic                out_valid_q, out_valid_d;
  face_t               out_q;

  logic [EW-1:0] x_e, y_e, z_e, xp_e, xm_e, yp_e, ym_e, zp_e, zm_e;
  logic          xp_ok, xm_ok, yp_ok, ym_ok, zp_ok, zm_ok;
  logic [XW-1:0] xi, xpi, xmi;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          rd_ok, rd_fire, wr_fire;
  logic [GRID_SIZE-1:0] wr_data, mod_row;
  logic          fire, one_left;
  logic [NUM_DIRS-1:0] low_bit;
  logic [DIR_W-1:0]    low_dir;
  logic          found;
  logic          emit_done;

  // Neighbor coordinates and their in-grid flags
  always_comb begin
    x_e   = EW'(req_q.pos_x);
    y_e   = EW'(req_q.pos_y);
    z_e   = EW'(req_q.pos_z);
    xp_e  = x_e + 8'd1;
    xm_e  = x_e - 8'd1;
    yp_e  = y_e + 8'd1;
    ym_e  = y_e - 8'd1;
    zp_e  = z_e + 8'd1;
    zm_e  = z_e - 8'd1;
    xp_ok = xp_e < GS;
    xm_ok = x_e != 8'd0;
    yp_ok = yp_e < GS;
    ym_ok = y_e != 8'd0;
    zp_ok = zp_e < GS;
    zm_ok = z_e != 8'd0;
    xi    = x_e[XW-1:0];
    xpi   = xp_e[XW-1:0];
    xmi   = xm_e[XW-1:0];
  end

  // Status from the incoming request
  always_comb begin
    sts_o.in_mesh   = in_req_i.operation == OP_MESH;
    sts_o.in_grid   = (EW'(in_req_i.pos_x) < GS) && (EW'(in_req_i.pos_y) < GS) &&
                      (EW'(in_req_i.pos_z) < GS);
    sts_o.clr_last  = clr_cnt_q == LAST_ROW;
    sts_o.emit_done = emit_done;
  end

  // Read address select; out-of-grid neighbors are not read
  always_comb begin
    case (cmd_i.rd_sel)
      ROW_CENTER: begin rd_addr = row_addr(y_e, z_e);  rd_ok = 1'b1;  end
      ROW_YP:     begin rd_addr = row_addr(yp_e, z_e); rd_ok = yp_ok; end
      ROW_YM:     begin rd_addr = row_addr(ym_e, z_e); rd_ok = ym_ok; end
      ROW_ZP:     begin rd_addr = row_addr(y_e, zp_e); rd_ok = zp_ok; end
      ROW_ZM:     begin rd_addr = row_addr(y_e, zm_e); rd_ok = zm_ok; end
      default:    begin rd_addr = '0;                  rd_ok = 1'b0;  end
    endcase
    rd_fire = cmd_i.rd_en && rd_ok;
  end

  // Write port: clear sweep or read-modify-write of one voxel bit
  always_comb begin
    mod_row     = rdata_q;
    mod_row[xi] = req_q.full_req;
    wr_fire     = cmd_i.clr_en || cmd_i.wr_row;
    wr_addr     = cmd_i.clr_en ? clr_cnt_q : row_addr(y_e, z_e);
    wr_data     = cmd_i.clr_en ? '0 : mod_row;
  end

  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_fire) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Lowest pending face in the mask
  always_comb begin
    low_bit = '0;
    low_dir = DIR_XP;
    found   = 1'b0;
    for (int i = 0; i < NUM_DIRS; i++) begin
      if (mask_q[i] && !found) begin
        found      = 1'b1;
        low_bit[i] = 1'b1;
        low_dir    = DIR_W'(i);
      end
    end
    one_left  = (mask_q & ~low_bit) == '0;
    fire      = cmd_i.emit_en && found && (!out_valid_q || out_ready_i);
    emit_done = !found || (fire && one_left);
  end

  // Exposure capture and mask consumption
  always_comb begin
    mask_d   = mask_q;
    center_d = center_q;
    case (cmd_i.cap_sel)
      CAP_X: begin
        center_d       = rdata_q[xi];
        mask_d[DIR_XP] = !(xp_ok && rdata_q[xpi]);
        mask_d[DIR_XM] = !(xm_ok && rdata_q[xmi]);
      end
      CAP_YP: mask_d[DIR_YP] = !(yp_ok && rdata_q[xi]);
      CAP_YM: mask_d[DIR_YM] = !(ym_ok && rdata_q[xi]);
      CAP_ZP: mask_d[DIR_ZP] = !(zp_ok && rdata_q[xi]);
      CAP_ZM: begin
        mask_d[DIR_ZM] = !(zm_ok && rdata_q[xi]);
        mask_d         = mask_d & {NUM_DIRS{center_q}};
      end
      default: ;
    endcase
    if (fire) begin
      mask_d = mask_q & ~low_bit;
    end
  end

  // Clear counter and output handshake
  always_comb begin
    clr_cnt_d = cmd_i.clr_en ? clr_cnt_q + AW'(1) : clr_cnt_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      mask_q      <= '0;
      center_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clr_cnt_q   <= clr_cnt_d;
      mask_q      <= mask_d;
      center_q    <= center_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_req_i;
    end
    if (fire) begin
      out_q.face_x   <= req_q.pos_x;
      out_q.face_y   <= req_q.pos_y;
      out_q.face_z   <= req_q.pos_z;
      out_q.face_dir <= low_dir;
      out_q.last     <= one_left;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_face_o  = out_q;

endmodule

@@ src/vfcm_ctrl.sv @@
// Controller of the voxel face mesher: sequences clear, write-back,
// the five row reads of a mesh (center and four neighbor rows) and face emission.
// Depends on vfcm_pkg.
module vfcm_ctrl import vfcm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.clr_en  = 1'b0;
    cmd_o.rd_en   = 1'b0;
    cmd_o.rd_sel  = ROW_CENTER;
    cmd_o.cap_sel = CAP_NONE;
    cmd_o.wr_row  = 1'b0;
    cmd_o.emit_en = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        if (in_valid_i && sts_i.in_grid) begin
          state_d = sts_i.in_mesh ? ST_M_C : ST_WR_RD;
        end
      end
      ST_WR_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_WR_WR;
      end
      ST_WR_WR: begin
        cmd_o.wr_row = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_M_C: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_M_YP;
      end
      ST_M_YP: begin
        cmd_o.cap_sel = CAP_X;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = ROW_YP;
        state_d       = ST_M_YM;
      end
      ST_M_YM: begin
        cmd_o.cap_sel = CAP_YP;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = ROW_YM;
        state_d       = ST_M_ZP;
      end
      ST_M_ZP: begin
        cmd_o.cap_sel = CAP_YM;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = ROW_ZP;
        state_d       = ST_M_ZM;
      end
      ST_M_ZM: begin
        cmd_o.cap_sel = CAP_ZP;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = ROW_ZM;
        state_d       = ST_M_END;
      end
      ST_M_END: begin
        cmd_o.cap_sel = CAP_ZM;
        state_d       = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit_en = 1'b1;
        if (sts_i.emit_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ src/vfcm_checker.sv @@
// Port-level checks for the voxel face mesher, bound to the top level.
// Depends on vfcm_pkg.
module vfcm_checker import vfcm_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_ready_o,
  input logic    out_valid_o,
  input logic    out_ready_i,
  input face_t   out_face_o
);

  // Stalled face stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("face output dropped while stalled");

  // Stalled face keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_face_o))
    else $error("face payload changed while stalled");

  // No new request while a run is still unfinished
  a_run_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_face_o.last |-> !in_ready_o)
    else $error("request taken in the middle of a face run");

  // A non-final face taken is followed at once by the next face
  a_run_dense: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_face_o.last |=>
      out_valid_o && out_face_o.face_dir > $past(out_face_o.face_dir) &&
      out_face_o.face_dir <= DIR_MAX)
    else $error("face run broken or out of order");

endmodule

bind voxel_face_culling_mesher_unit vfcm_checker u_vfcm_checker (.*);

@@ test/tb_top.sv @@
// Testbench for voxel_face_culling_mesher_unit: directed stimulus plus random requests,
// with every face record checked against a hand-written mask or an in-bench occupancy model.
// Depends on vfcm_pkg and voxel_face_culling_mesher_unit.
module tb_top;
  import vfcm_pkg::*;

  localparam int GRID         = 16;
  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_REQS  = 200;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 200_000;

  localparam logic [NUM_DIRS-1:0] NO_FACES  = '0;
  localparam logic [NUM_DIRS-1:0] ALL_FACES = '1;

  // One directed row: request, plus a hand-written face mask where typed is set
  typedef struct {
    in_req_t             req;
    bit                  typed;
    logic [NUM_DIRS-1:0] faces;
  } step_t;

  logic    clk_i = 1'b0;
  logic    rst_ni;
  logic    req_valid;
  logic    req_ready;
  in_req_t req;
  logic    face_valid;
  logic    face_ready;
  face_t   face;

  // Occupancy model and faces still owed by the block
  bit    voxel_map [GRID*GRID*GRID];
  face_t pending_faces[$];

  int errors      = 0;
  int n_req       = 0;
  int n_mesh      = 0;
  int n_faces     = 0;
  int burst_left  = 0;
  bit rand_phase  = 1'b0;
  bit hold_done   = 1'b0;

  voxel_face_culling_mesher_unit #(
    .GRID_SIZE (GRID)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_valid),
    .in_ready_o  (req_ready),
    .in_req_i    (req),
    .out_valid_o (face_valid),
    .out_ready_i (face_ready),
    .out_face_o  (face)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Occupancy lookup; anything off the grid is empty
  function automatic bit solid_at(int x, int y, int z);
    if (x < 0 || x >= GRID || y < 0 || y >= GRID || z < 0 || z >= GRID) begin
      return 1'b0;
    end
    return voxel_map[x + y * GRID + z * GRID * GRID];
  endfunction

  // Exposure mask of a voxel, bit position = face direction code
  function automatic logic [NUM_DIRS-1:0] exposed_faces(in_req_t r);
    int x;
    int y;
    int z;
    logic [NUM_DIRS-1:0] m;
    x = r.pos_x;
    y = r.pos_y;
    z = r.pos_z;
    m = NO_FACES;
    if (!solid_at(x, y, z)) begin
      return m;
    end
    m[DIR_XP] = !solid_at(x + 1, y, z);
    m[DIR_XM] = !solid_at(x - 1, y, z);
    m[DIR_YP] = !solid_at(x, y + 1, z);
    m[DIR_YM] = !solid_at(x, y - 1, z);
    m[DIR_ZP] = !solid_at(x, y, z + 1);
    m[DIR_ZM] = !solid_at(x, y, z - 1);
    return m;
  endfunction

  // Turn a mask into face records in direction order, last on the final one
  task automatic queue_faces(in_req_t r, logic [NUM_DIRS-1:0] mask);
    int    top;
    face_t f;
    top = -1;
    for (int d = 0; d < NUM_DIRS; d++) begin
      if (mask[d]) top = d;
    end
    for (int d = 0; d < NUM_DIRS; d++) begin
      if (mask[d]) begin
        f.face_x   = r.pos_x;
        f.face_y   = r.pos_y;
        f.face_z   = r.pos_z;
        f.face_dir = DIR_W'(d);
        f.last     = (d == top);
        pending_faces.push_back(f);
      end
    end
  endtask

  // Update the model for an accepted request
  task automatic apply_request(in_req_t r, bit typed, logic [NUM_DIRS-1:0] mask);
    n_req++;
    if (r.operation == OP_WRITE) begin
      voxel_map[r.pos_x + r.pos_y * GRID + r.pos_z * GRID * GRID] = r.full_req;
    end else begin
      n_mesh++;
      queue_faces(r, typed ? mask : exposed_faces(r));
    end
  endtask

  // Offer one request in bursts; called and returns at a falling edge
  task automatic offer(in_req_t r, bit typed, logic [NUM_DIRS-1:0] mask);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 8);
    end
    burst_left--;
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk_i); while (!req_ready);
    apply_request(r, typed, mask);
    @(negedge clk_i);
  endtask

  function automatic step_t row(logic op, int x, int y, int z, logic full, bit typed,
                                logic [NUM_DIRS-1:0] mask);
    step_t s;
    s.req.operation = op;
    s.req.pos_x     = COORD_W'(x);
    s.req.pos_y     = COORD_W'(y);
    s.req.pos_z     = COORD_W'(z);
    s.req.full_req  = full;
    s.typed         = typed;
    s.faces         = mask;
    return s;
  endfunction

  // Face output check against the oldest pending record
  always @(posedge clk_i) begin
    if (rst_ni && face_valid && face_ready) begin
      if (pending_faces.size() == 0) begin
        $error("unexpected face record x=%0d y=%0d z=%0d dir=%0d",
               face.face_x, face.face_y, face.face_z, face.face_dir);
        errors++;
      end else begin
        if (face.face_x !== pending_faces[0].face_x) begin
          $error("face_x expected %0d got %0d", pending_faces[0].face_x, face.face_x);
          errors++;
        end
        if (face.face_y !== pending_faces[0].face_y) begin
          $error("face_y expected %0d got %0d", pending_faces[0].face_y, face.face_y);
          errors++;
        end
        if (face.face_z !== pending_faces[0].face_z) begin
          $error("face_z expected %0d got %0d", pending_faces[0].face_z, face.face_z);
          errors++;
        end
        if (face.face_dir !== pending_faces[0].face_dir) begin
          $error("face_dir expected %0d got %0d", pending_faces[0].face_dir, face.face_dir);
          errors++;
        end
        if (face.last !== pending_faces[0].last) begin
          $error("last expected %0d got %0d", pending_faces[0].last, face.last);
          errors++;
        end
        void'(pending_faces.pop_front());
        n_faces++;
      end
    end
  end

  // Output side: changing stall modes, plus one long hold-off once random traffic runs
  initial begin : face_sink
    int mode;
    int span;
    face_ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      if (rand_phase && !hold_done) begin
        hold_done = 1'b1;
        @(negedge clk_i) face_ready <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(negedge clk_i);
      end else begin
        for (int k = 0; k < span; k++) begin
          @(negedge clk_i);
          case (mode)
            0: begin
              face_ready <= 1'b1;
            end
            1: begin
              face_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
              face_ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
              face_ready <= (k % 3 != 0);
            end
          endcase
        end
      end
    end
  end

  // Run limit
  initial begin : watchdog
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("TEST FAILED");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    step_t   plan[$];
    in_req_t r;
    int      wx;
    int      wy;
    int      wz;
    rst_ni    = 1'b0;
    req_valid = 1'b0;
    req       = '0;

    // Empty grid, isolated voxels at three corners, a shared face, an enclosed voxel and its removal
    plan.push_back(row(OP_MESH,   0,  0,  0, 1'b0, 1'b1, NO_FACES));
    plan.push_back(row(OP_MESH,  15, 15, 15, 1'b0, 1'b1, NO_FACES));
    plan.push_back(row(OP_WRITE,  0,  0,  0, 1'b1, 1'b0, NO_FACES));
    plan.push_back(row(OP_MESH,   0,  0,  0, 1'b0, 1'b1, ALL_FACES));
    plan.push_back(row(OP_WRITE, 15, 15, 15, 1'b1, 1'b0, NO_FACES));
    plan.push_back(row(OP_MESH,  15, 15, 15, 1'b1, 1'b1, ALL_FACES));
    plan.push_back(row(OP_WRITE,  1,  0,  0, 1'b1, 1'b0, NO_FACES));
    plan.push_back(row(OP_MESH,   0,  0,  0, 1'b0, 1'b1, ALL_FACES & ~(6'b1 << DIR_XP)));
    plan.push_back(row(OP_MESH,   1,  0,  0, 1'b0, 1'b1, ALL_FACES & ~(6'b1 << DIR_XM)));
    plan.push_back(row(OP_WRITE,  5,  5,  5, 1'b1, 1'b0, NO_FACES));
    plan.push_back(row(OP_WRITE,  6,  5,  5, 1'b1, 1'b0, NO_FACES));
    plan.push_back(row(OP_WRITE,  4,  5,  5, 1'b1, 1'b0, NO_FACES));
    plan.push_back(row(OP_WRITE,  5,  6,  5, 1'b1, 1'b0, NO_FACES));
    plan.push_back(row(OP_WRITE,  5,  4,  5, 1'b1, 1'b0, NO_FACES));
    plan.push_back(row(OP_WRITE,  5,  5,  6, 1'b1, 1'b0, NO_FACES));
    plan.push_back(row(OP_WRITE,  5,  5,  4, 1'b1, 1'b0, NO_FACES));
    plan.push_back(row(OP_MESH,   5,  5,  5, 1'b0, 1'b1, NO_FACES));
    plan.push_back(row(OP_MESH,   5,  6,  5, 1'b0, 1'b0, NO_FACES));
    plan.push_back(row(OP_WRITE,  5,  5,  5, 1'b0, 1'b0, NO_FACES));
    plan.push_back(row(OP_MESH,   5,  5,  5, 1'b1, 1'b1, NO_FACES));
    plan.push_back(row(OP_MESH,   5,  5,  6, 1'b0, 1'b0, NO_FACES));
    plan.push_back(row(OP_WRITE, 15,  0, 15, 1'b1, 1'b0, NO_FACES));
    plan.push_back(row(OP_MESH,  15,  0, 15, 1'b0, 1'b1, ALL_FACES));
    plan.push_back(row(OP_WRITE,  0,  0,  0, 1'b0, 1'b0, NO_FACES));
    plan.push_back(row(OP_MESH,   1,  0,  0, 1'b0, 1'b0, NO_FACES));

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      offer(plan[i].req, plan[i].typed, plan[i].faces);
    end

    // Random traffic, mostly clustered in a 4x4x4 window so meshes see neighbors
    rand_phase = 1'b1;
    wx = 0;
    wy = 0;
    wz = 0;
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i % 40 == 0) begin
        wx = $urandom_range(0, 3) * 4;
        wy = $urandom_range(0, 3) * 4;
        wz = $urandom_range(0, 3) * 4;
      end
      r.operation = ($urandom_range(0, 99) < 45) ? OP_WRITE : OP_MESH;
      if ($urandom_range(0, 3) != 0) begin
        r.pos_x = COORD_W'(wx + $urandom_range(0, 3));
        r.pos_y = COORD_W'(wy + $urandom_range(0, 3));
        r.pos_z = COORD_W'(wz + $urandom_range(0, 3));
      end else begin
        r.pos_x = COORD_W'($urandom_range(0, GRID - 1));
        r.pos_y = COORD_W'($urandom_range(0, GRID - 1));
        r.pos_z = COORD_W'($urandom_range(0, GRID - 1));
      end
      r.full_req = (r.operation == OP_WRITE) ? ($urandom_range(0, 3) != 0)
                                             : 1'($urandom_range(0, 1));
      offer(r, 1'b0, NO_FACES);
    end
    req_valid <= 1'b0;

    while (pending_faces.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d requests (%0d mesh) with %0d face records checked,", n_req, n_mesh,
             n_faces);
    $display("including grid edges, enclosed voxels and a long output hold-off.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ voxel_face_culling_mesher_unit.f @@
src/vfcm_pkg.sv
src/vfcm_datapath.sv
src/vfcm_ctrl.sv
src/voxel_face_culling_mesher_unit.sv
src/vfcm_checker.sv
test/tb_top.sv
